// ===== rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
  localparam int OperandWidth = 32;
  localparam int WideWidth = 64;
  localparam int CntWidth = 7;
  localparam logic [CntWidth-1:0] MulLast = CntWidth'(OperandWidth - 1);
  localparam logic [CntWidth-1:0] DivLast = CntWidth'(WideWidth - 1);

  typedef enum logic [2:0] {
    OpAdd = 3'd0, OpSub = 3'd1, OpMul = 3'd2, OpDiv = 3'd3,
    OpLess = 3'd4, OpEqual = 3'd5, OpNeg = 3'd6, OpNorm = 3'd7
  } op_e;
endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit.
// Input channel: in_valid_i / in_stall_o carry one request (req_type, two
// signed fractions). Output channel: out_valid_o / out_stall_i carry one
// result (reduced numerator, nonnegative denominator, compare flag, add
// overflow flag). A request is taken when valid is high and stall is low.
// Each request is worked by one shared 64-bit add/subtract unit under a
// small sequencer: cross products by shift-and-add (two, or three for add
// and subtract), then a binary gcd (data dependent) and two restoring
// divisions by the gcd; compares and negate skip the gcd and divisions.
// One request at a time, so a new request is taken no earlier than the
// cycle in which the result is taken. The result register holds while
// the receiver stalls, and in_stall_o stays high until the result has
// been taken.
// Reset clears the sequencer and the output valid; payload is not reset.
`default_nettype none
module rational_arithmetic_unit_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic signed [31:0] a_num_i,
  input  wire logic signed [31:0] a_den_i,
  input  wire logic signed [31:0] b_num_i,
  input  wire logic signed [31:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [63:0] res_num_o,
  output logic [62:0]      res_den_o,
  output logic             cmp_true_o,
  output logic             overflow_o
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StMul1, StMul2, StSum, StMul3, StPrep, StGcdSh, StGcd, StDivN, StDivD, StOut
  } state_e;

  state_e state_q;
  op_e op_q;
  logic [WideWidth-1:0] mc_q, acc_q, p1_q, x_q, y_q, g_q;
  logic [WideWidth-1:0] q_q, r_q, dvd_q;
  logic [OperandWidth-1:0] mp_q;
  logic [CntWidth-1:0] cnt_q, sh_q;
  logic [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic nneg_q, dneg_q, ovf_q;
  logic [WideWidth-1:0] nmag_q, dmag_q;

  // shared adder; on subtract the top bit is the borrow
  logic [WideWidth-1:0] add_a, add_b;
  logic add_sub;
  logic [WideWidth:0] add_r;
  assign add_r = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                         : ({1'b0, add_a} + {1'b0, add_b});

  function automatic logic [WideWidth-1:0] sx(input logic [OperandWidth-1:0] v);
    return {{(WideWidth-OperandWidth){v[OperandWidth-1]}}, v};
  endfunction
  function automatic logic [WideWidth-1:0] mag(input logic [WideWidth-1:0] v);
    return v[WideWidth-1] ? (~v + 64'd1) : v;
  endfunction

  logic [WideWidth-1:0] rshift;
  assign rshift = {r_q[WideWidth-2:0], dvd_q[WideWidth-1]};

  always_comb begin
    add_a = acc_q; add_b = mc_q; add_sub = 1'b0;
    unique case (state_q)
      // top multiplier bit weighs negative
      StMul1, StMul2, StMul3: add_sub = (cnt_q == MulLast);
      StGcd: begin add_a = y_q; add_b = x_q; add_sub = 1'b1; end
      StDivN, StDivD: begin add_a = rshift; add_b = g_q; add_sub = 1'b1; end
      StSum: begin
        add_a = p1_q; add_b = acc_q;
        add_sub = (op_q == OpSub);
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != StIdle) || (out_valid_o && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
          if (in_valid_i && !(out_valid_o && out_stall_i)) begin
            op_q <= op_e'(req_type_i);
            an_q <= a_num_i[OperandWidth-1:0]; ad_q <= a_den_i[OperandWidth-1:0];
            bn_q <= b_num_i[OperandWidth-1:0]; bd_q <= b_den_i[OperandWidth-1:0];
            // first product: a_num*b_den for add/sub/div/cmp, a_num*b_num for mul
            mc_q <= sx(a_num_i[OperandWidth-1:0]);
            mp_q <= (req_type_i == OpMul) ? b_num_i[OperandWidth-1:0]
                                          : b_den_i[OperandWidth-1:0];
            acc_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
            state_q <= StMul1;
          end
        end
        StMul1, StMul2, StMul3: begin
          logic [WideWidth-1:0] pr;
          pr = mp_q[0] ? add_r[WideWidth-1:0] : acc_q;
          acc_q <= pr;
          mc_q <= mc_q << 1;
          mp_q <= mp_q >> 1;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            if (state_q == StMul1) begin
              p1_q <= pr;
              acc_q <= '0;
              unique case (op_q)
                OpAdd, OpSub: begin mc_q <= sx(bn_q); mp_q <= ad_q; end
                OpMul, OpNeg, OpNorm: begin mc_q <= sx(ad_q); mp_q <= bd_q; end
                default: begin mc_q <= sx(ad_q); mp_q <= bn_q; end
              endcase
              state_q <= StMul2;
            end else if (state_q == StMul2 && (op_q == OpAdd || op_q == OpSub)) begin
              state_q <= StSum;
            end else begin
              state_q <= StPrep;
            end
          end
        end
        StSum: begin
          // p1 +/- second product, then the common denominator
          p1_q <= add_r[WideWidth-1:0];
          ovf_q <= (p1_q[63] == (add_sub ? ~acc_q[63] : acc_q[63])) &&
                   (add_r[63] != p1_q[63]);
          mc_q <= sx(ad_q); mp_q <= bd_q;
          acc_q <= '0; cnt_q <= '0;
          state_q <= StMul3;
        end
        StPrep: begin
          // acc = last product, p1 = first product or sum
          logic [WideWidth-1:0] n, d;
          cmp_true_o <= 1'b0;
          n = p1_q; d = acc_q;
          if (op_q == OpNorm) begin
            n = sx(an_q); d = sx(ad_q);
          end
          nneg_q <= n[63]; dneg_q <= d[63];
          nmag_q <= mag(n); dmag_q <= mag(d);
          x_q <= mag(n); y_q <= mag(d); sh_q <= '0;
          if (op_q == OpLess || op_q == OpEqual) begin
            cmp_true_o <= (op_q == OpLess) ? ($signed(p1_q) < $signed(acc_q))
                                           : (p1_q == acc_q);
            res_num_o <= '0; res_den_o <= '0; overflow_o <= 1'b0;
            state_q <= StOut;
          end else if (op_q == OpNeg) begin
            if (ad_q[OperandWidth-1]) begin
              res_num_o <= sx(an_q); res_den_o <= 63'(-sx(ad_q));
            end else begin
              res_num_o <= -sx(an_q); res_den_o <= 63'(sx(ad_q));
            end
            overflow_o <= 1'b0;
            state_q <= StOut;
          end else state_q <= StGcdSh;
        end
        StGcdSh: begin
          // binary gcd: strip common factors of two first
          if (x_q == 0 || y_q == 0) begin
            g_q <= x_q | y_q; state_q <= StDivN;
            dvd_q <= nmag_q; r_q <= '0; cnt_q <= '0;
          end else if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 7'd1;
          end else begin
            state_q <= StGcd;
            if (!x_q[0]) x_q <= y_q;
            if (!x_q[0]) y_q <= x_q;
          end
        end
        StGcd: begin
          // x odd; drop twos from y, swap when y < x, else y := y - x
          if (y_q == 0) begin
            g_q <= x_q << sh_q; state_q <= StDivN;
            dvd_q <= nmag_q; r_q <= '0; cnt_q <= '0;
          end else if (!y_q[0]) y_q <= y_q >> 1;
          else if (add_r[WideWidth]) begin
            x_q <= y_q; y_q <= x_q;
          end else y_q <= add_r[WideWidth-1:0];
        end
        StDivN, StDivD: begin
          if (g_q == 0) begin
            res_num_o <= '0; res_den_o <= 63'd1; overflow_o <= ovf_q;
            state_q <= StOut;
          end else if (dmag_q == 0) begin
            res_num_o <= 64'd1; res_den_o <= '0; overflow_o <= ovf_q;
            state_q <= StOut;
          end else begin
            logic [WideWidth-1:0] qn;
            qn = {q_q[WideWidth-2:0], !add_r[WideWidth]};
            r_q <= add_r[WideWidth] ? rshift : add_r[WideWidth-1:0];
            dvd_q <= dvd_q << 1;
            q_q <= qn;
            cnt_q <= cnt_q + 7'd1;
            if (cnt_q == DivLast) begin
              cnt_q <= '0; r_q <= '0;
              if (state_q == StDivN) begin
                res_num_o <= (nneg_q != dneg_q) ? -qn : qn;
                dvd_q <= dmag_q; state_q <= StDivD;
              end else begin
                res_den_o <= qn[62:0]; overflow_o <= ovf_q;
                state_q <= StOut;
              end
            end
          end
        end
        StOut: begin
          out_valid_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
